>>> design/vn_pkg.sv
// ----------------------------------------------------------------------------
// Vector normalize package
// Widths, stage counts and reset values shared by the normalize unit and its
// channel interfaces.
// ----------------------------------------------------------------------------
package vn_pkg;

  localparam int unsigned CompWidth  = 32;   // input component, signed Q16.16
  localparam int unsigned OutWidth   = 18;   // output component, signed Q2.16
  localparam int unsigned LenWidth   = 32;   // reported length, unsigned Q16.16
  localparam int unsigned MinWidth   = 17;   // threshold register
  localparam int unsigned SumWidth   = 64;   // sum of squares, Q32.32
  localparam int unsigned RootWidth  = 33;   // rounded root before truncation
  localparam int unsigned SqrtStages = SumWidth / 2;
  localparam int unsigned QuotWidth  = 17;   // normalized magnitude, 0..65536
  localparam int unsigned NumWidth   = CompWidth + QuotWidth + 1;

  localparam logic [MinWidth-1:0] MinLengthReset = MinWidth'(1);

  typedef logic signed [CompWidth-1:0] comp_t;
  typedef logic signed [OutWidth-1:0]  out_comp_t;

endpackage

>>> design/vn_in_if.sv
// ----------------------------------------------------------------------------
// Vector input channel
// Valid/ready channel carrying one three-component vector word.
// ----------------------------------------------------------------------------
interface vn_in_if;
  logic           valid;
  logic           ready;
  vn_pkg::comp_t  in_x;
  vn_pkg::comp_t  in_y;
  vn_pkg::comp_t  in_z;

  modport source (output valid, output in_x, output in_y, output in_z, input ready);
  modport sink   (input valid, input in_x, input in_y, input in_z, output ready);
endinterface

>>> design/vn_out_if.sv
// ----------------------------------------------------------------------------
// Vector result channel
// Valid/ready channel carrying one normalized vector word with its length.
// ----------------------------------------------------------------------------
interface vn_out_if;
  logic                          valid;
  logic                          ready;
  vn_pkg::out_comp_t             out_x;
  vn_pkg::out_comp_t             out_y;
  vn_pkg::out_comp_t             out_z;
  logic [vn_pkg::LenWidth-1:0]   length;
  logic                          skipped;

  modport source (output valid, output out_x, output out_y, output out_z,
                  output length, output skipped, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z,
                  input length, input skipped, output ready);
endinterface

>>> design/vn_cfg_if.sv
// ----------------------------------------------------------------------------
// Threshold write channel
// Valid/ready channel carrying the minimum length register write word.
// ----------------------------------------------------------------------------
interface vn_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [vn_pkg::MinWidth-1:0]   min_length;

  modport source (output valid, output min_length, input ready);
  modport sink   (input valid, input min_length, output ready);
endinterface

>>> design/vector3_normalize_unit.sv
// ----------------------------------------------------------------------------
// Three-component vector normalize unit
// Computes the rounded Euclidean length of a signed Q16.16 vector and divides
// each component by it, or passes the vector through when it is too short.
// ----------------------------------------------------------------------------
//
//  Channel   Role   Word contents
//  vec_in    sink   in_x, in_y, in_z (signed Q16.16)
//  vec_out   source out_x, out_y, out_z, length, skipped
//  cfg       sink   min_length (unsigned Q1.16, reset value 1)
//
// The unit accepts one word per cycle while vec_out is not stalled. Each
// accepted word passes through 54 register stages: one multiply stage, one
// sum stage, 32 square-root stages (one root bit each), one rounding and
// threshold stage, one divider load stage, 17 divider stages (one quotient
// bit each) and the output register. Reset clears every valid bit and sets
// min_length to 1. A stall on vec_out freezes the whole pipeline, so nothing
// is dropped or repeated; cfg writes are always taken.

module vector3_normalize_unit (
  input  logic        clk,
  input  logic        rst,
  vn_in_if.sink       vec_in,
  vn_out_if.source    vec_out,
  vn_cfg_if.sink      cfg
);

  localparam int unsigned CW = vn_pkg::CompWidth;
  localparam int unsigned SW = vn_pkg::SumWidth;
  localparam int unsigned NS = vn_pkg::SqrtStages;
  localparam int unsigned RW = vn_pkg::RootWidth;
  localparam int unsigned QW = vn_pkg::QuotWidth;
  localparam int unsigned NW = vn_pkg::NumWidth;
  localparam int unsigned OW = vn_pkg::OutWidth;

  // Threshold register.
  logic [vn_pkg::MinWidth-1:0] min_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_length <= vn_pkg::MinLengthReset;
    end else if (cfg.valid) begin
      min_length <= cfg.min_length;
    end
  end

  assign cfg.ready = 1'b1;

  // The pipeline moves as one piece whenever the output register is free or
  // being emptied this cycle.
  logic advance;
  assign advance      = !vec_out.valid || vec_out.ready;
  assign vec_in.ready = advance;

  // Stage A: magnitudes squared, one 32x32 product per lane.
  logic [2:0][CW-1:0] in_c;
  logic [2:0][CW-1:0] in_mag;
  logic               a_valid;
  logic [2:0][CW-1:0] a_c;
  logic [2:0][SW-1:0] a_sq;

  assign in_c = {vec_in.in_z, vec_in.in_y, vec_in.in_x};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_mag[i] = in_c[i][CW-1] ? (~in_c[i] + CW'(1)) : in_c[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (advance) begin
      a_valid <= vec_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_c <= in_c;
      for (int i = 0; i < 3; i++) begin
        a_sq[i] <= SW'(in_mag[i]) * SW'(in_mag[i]);
      end
    end
  end

  // Stage B and the square-root chain. Index 0 holds the sum of squares;
  // index k+1 holds the state after root iteration k. The sum never exceeds
  // three times 2^62, so 64 bits hold it.
  logic               sq_valid [0:NS];
  logic [2:0][CW-1:0] sq_c     [0:NS];
  logic [SW-1:0]      sq_rem   [0:NS];
  logic [SW-1:0]      sq_res   [0:NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid[0] <= 1'b0;
    end else if (advance) begin
      sq_valid[0] <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sq_c[0]   <= a_c;
      sq_rem[0] <= a_sq[0] + a_sq[1] + a_sq[2];
      sq_res[0] <= '0;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    // Trial bit walks down two places per stage from bit 62.
    localparam logic [SW-1:0] TrialBit = SW'(1) << (SW - 2 - 2 * k);
    logic [SW-1:0] trial;
    logic          take;

    assign trial = sq_res[k] + TrialBit;
    assign take  = sq_rem[k] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_valid[k+1] <= 1'b0;
      end else if (advance) begin
        sq_valid[k+1] <= sq_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        sq_c[k+1] <= sq_c[k];
        if (take) begin
          sq_rem[k+1] <= sq_rem[k] - trial;
          sq_res[k+1] <= (sq_res[k] >> 1) + TrialBit;
        end else begin
          sq_rem[k+1] <= sq_rem[k];
          sq_res[k+1] <= sq_res[k] >> 1;
        end
      end
    end
  end

  // Stage R: round the root to nearest and compare with the threshold.
  logic               r_valid;
  logic [2:0][CW-1:0] r_c;
  logic [RW-1:0]      r_len;
  logic               r_skip;
  logic               r_zero;
  logic [RW-1:0]      len_round;

  assign len_round = RW'(sq_res[NS]) + RW'(sq_rem[NS] > sq_res[NS]);

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (advance) begin
      r_valid <= sq_valid[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      r_c    <= sq_c[NS];
      r_len  <= len_round;
      r_skip <= len_round < RW'(min_length);
      r_zero <= len_round == '0;
    end
  end

  // Divider chain: restoring division of (|c| << 17) + len by 2 * len, one
  // quotient bit per stage, three lanes side by side. The quotient stays
  // at or below 65536, so 17 bits suffice.
  logic               dv_valid [0:QW];
  logic [2:0][CW-1:0] dv_c     [0:QW];
  logic [RW-1:0]      dv_len   [0:QW];
  logic               dv_skip  [0:QW];
  logic               dv_zero  [0:QW];
  logic [2:0][NW-1:0] dv_rem   [0:QW];
  logic [2:0][QW-1:0] dv_q     [0:QW];

  logic [2:0][CW-1:0] r_mag;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      r_mag[i] = r_c[i][CW-1] ? (~r_c[i] + CW'(1)) : r_c[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else if (advance) begin
      dv_valid[0] <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dv_c[0]    <= r_c;
      dv_len[0]  <= r_len;
      dv_skip[0] <= r_skip;
      dv_zero[0] <= r_zero;
      dv_q[0]    <= '0;
      for (int i = 0; i < 3; i++) begin
        dv_rem[0][i] <= (NW'(r_mag[i]) << QW) + NW'(r_len);
      end
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int unsigned Shift = QW - 1 - j;
    logic [NW:0]   trial;
    logic [2:0]    take;

    assign trial = (NW+1)'({dv_len[j], 1'b0}) << Shift;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        take[i] = (NW+1)'(dv_rem[j][i]) >= trial;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[j+1] <= 1'b0;
      end else if (advance) begin
        dv_valid[j+1] <= dv_valid[j];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        dv_c[j+1]    <= dv_c[j];
        dv_len[j+1]  <= dv_len[j];
        dv_skip[j+1] <= dv_skip[j];
        dv_zero[j+1] <= dv_zero[j];
        for (int i = 0; i < 3; i++) begin
          if (take[i]) begin
            dv_rem[j+1][i] <= NW'((NW+1)'(dv_rem[j][i]) - trial);
          end else begin
            dv_rem[j+1][i] <= dv_rem[j][i];
          end
          dv_q[j+1][i] <= dv_q[j][i] | (QW'(take[i]) << Shift);
        end
      end
    end
  end

  // Output register: pick pass-through, zero or signed quotient.
  logic [2:0][OW-1:0] out_sel;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_skip[QW]) begin
        out_sel[i] = dv_c[QW][i][OW-1:0];
      end else if (dv_zero[QW]) begin
        out_sel[i] = '0;
      end else if (dv_c[QW][i][CW-1]) begin
        out_sel[i] = ~OW'(dv_q[QW][i]) + OW'(1);
      end else begin
        out_sel[i] = OW'(dv_q[QW][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vec_out.valid <= 1'b0;
    end else if (advance) begin
      vec_out.valid <= dv_valid[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      vec_out.out_x   <= out_sel[0];
      vec_out.out_y   <= out_sel[1];
      vec_out.out_z   <= out_sel[2];
      vec_out.length  <= dv_len[QW][vn_pkg::LenWidth-1:0];
      vec_out.skipped <= dv_skip[QW];
    end
  end

  // A skipped vector must really be shorter than the threshold.
  assert property (@(posedge clk) disable iff (rst)
    vec_out.valid && vec_out.skipped |->
      RW'(vec_out.length) < RW'(min_length))
    else $error("skipped result not below threshold");

  // The x and y components of a normalized result lie within plus or minus one.
  assert property (@(posedge clk) disable iff (rst)
    vec_out.valid && !vec_out.skipped |->
      vec_out.out_x >= -OW'(65536) && vec_out.out_x <= OW'(65536) &&
      vec_out.out_y >= -OW'(65536) && vec_out.out_y <= OW'(65536))
    else $error("normalized component out of range");

  // A zero-length vector that is not skipped reads as all zeros.
  assert property (@(posedge clk) disable iff (rst)
    vec_out.valid && !vec_out.skipped && vec_out.length == '0 |->
      vec_out.out_x == '0 && vec_out.out_y == '0 && vec_out.out_z == '0)
    else $error("zero-length vector not cleared");

endmodule
